/* design/vpsm_pkg.sv */
// shared types for the vector pair similarity metrics block
// command and status bundles between controller and datapath; no dependencies
package vpsm_pkg;

  localparam int DIV_STEPS  = 33;
  localparam int SQRT_STEPS = 17;
  localparam int DRAIN_CYC  = 2;

  typedef struct packed {
    logic load;
    logic clear;
    logic sweep_init;
    logic sweep_rd;
    logic div_ex_init;
    logic div_q_init;
    logic div_step;
    logic ex_latch;
    logic mul_p_init;
    logic mul_d_init;
    logic p_latch;
    logic mul_step;
    logic sqrt_init;
    logic sqrt_step;
    logic res_load;
  } vpsm_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic zero_norm;
  } vpsm_sts_t;

endpackage

/* design/vector_pair_similarity_metrics.sv */
// top level of the vector pair similarity metrics block
// joins vpsm_ctrl and vpsm_dpath; uses vpsm_pkg
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: first_value, second_value; tlast: last_pair
//  out_    | out | out_tvalid/tready  | tdata: visibility, coherence, bell_excess, ortho
//
// loading takes one element pair per cycle while the input is ready
// after the last pair the block walks the n stored pairs, then runs
// a 33-step divide, two shift-add multiplies of 30+clog2(MAX_DIM+1) steps each,
// another 33-step divide and a 17-step root before the result shows; when a norm
// is zero it goes to the result straight after the first divide
// a finished result waits in the output register while the next vectors load
// reset is synchronous and active low; no clearing pass, stores are written before read
module vector_pair_similarity_metrics import vpsm_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // first_value[15:0], second_value[31:16]
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // visibility[16:0], coherence[33:17],
                                  // bell_excess[53:34], ortho[94:54], zero pad
);

  localparam int NW = 30 + $clog2(MAX_DIM + 1);

  vpsm_cmd_t          cmd;
  vpsm_sts_t          sts;
  logic [16:0]        visibility;
  logic [16:0]        coherence;
  logic signed [19:0] bell_excess;
  logic [40:0]        ortho;

  // sequencing of load, sweep and the iterative units
  vpsm_ctrl #(.NW(NW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // stores, accumulators and arithmetic
  vpsm_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .first_value  (in_tdata[15:0]),
    .second_value (in_tdata[31:16]),
    .visibility   (visibility),
    .coherence    (coherence),
    .bell_excess  (bell_excess),
    .ortho        (ortho)
  );

  // fields packed from the lowest bit up
  assign out_tdata = {1'b0, ortho, bell_excess, coherence, visibility};

endmodule

/* design/vpsm_ctrl.sv */
// controller state machine of the vector pair similarity metrics block
// sequences load, correlation sweep, division, multiply and root steps; uses vpsm_pkg
module vpsm_ctrl import vpsm_pkg::*; #(
  parameter int NW = 41
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  vpsm_sts_t sts,
  output vpsm_cmd_t cmd
);

  localparam int MAXSTEP = (NW > DIV_STEPS) ? NW : DIV_STEPS;
  localparam int SCW     = $clog2(MAXSTEP + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_SETUP, S_SWEEP, S_DRAIN, S_EX_INIT, S_EX_DIV, S_EX_END,
    S_P_INIT, S_P_MUL, S_D_INIT, S_D_MUL, S_Q_INIT, S_Q_DIV, S_R_INIT,
    S_R_SQRT, S_DONE
  } state_t;

  state_t          state_r;
  logic [SCW-1:0]  cnt_r;
  logic            out_valid_r;
  logic            in_acc;
  logic            out_free;

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd             = '0;
    cmd.load        = in_acc;
    cmd.sweep_init  = (state_r == S_SETUP);
    cmd.sweep_rd    = (state_r == S_SWEEP);
    cmd.div_ex_init = (state_r == S_EX_INIT);
    cmd.div_q_init  = (state_r == S_Q_INIT);
    cmd.div_step    = (state_r == S_EX_DIV) || (state_r == S_Q_DIV);
    cmd.ex_latch    = (state_r == S_EX_END);
    cmd.mul_p_init  = (state_r == S_P_INIT);
    cmd.mul_d_init  = (state_r == S_D_INIT);
    cmd.p_latch     = (state_r == S_D_INIT);
    cmd.mul_step    = (state_r == S_P_MUL) || (state_r == S_D_MUL);
    cmd.sqrt_init   = (state_r == S_R_INIT);
    cmd.sqrt_step   = (state_r == S_R_SQRT);
    cmd.res_load    = (state_r == S_DONE) && out_free;
    cmd.clear       = cmd.res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc && in_tlast) begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP:   state_r <= S_SWEEP;
        S_SWEEP: begin
          if (sts.sweep_last) begin
            state_r <= S_DRAIN;
            cnt_r   <= '0;
          end
        end
        S_DRAIN: begin
          if (cnt_r == SCW'(DRAIN_CYC - 1)) begin
            state_r <= S_EX_INIT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EX_INIT: state_r <= S_EX_DIV;
        S_EX_DIV: begin
          if (cnt_r == SCW'(DIV_STEPS - 1)) begin
            state_r <= S_EX_END;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EX_END:  state_r <= sts.zero_norm ? S_DONE : S_P_INIT;
        S_P_INIT:  state_r <= S_P_MUL;
        S_P_MUL: begin
          if (cnt_r == SCW'(NW - 1)) begin
            state_r <= S_D_INIT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_D_INIT:  state_r <= S_D_MUL;
        S_D_MUL: begin
          if (cnt_r == SCW'(NW - 1)) begin
            state_r <= S_Q_INIT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_Q_INIT:  state_r <= S_Q_DIV;
        S_Q_DIV: begin
          if (cnt_r == SCW'(DIV_STEPS - 1)) begin
            state_r <= S_R_INIT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_R_INIT:  state_r <= S_R_SQRT;
        S_R_SQRT: begin
          if (cnt_r == SCW'(SQRT_STEPS - 1)) begin
            state_r <= S_DONE;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == S_SETUP))
    else $error("last request did not start the sweep");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending result");
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown outside the done step");
`endif

endmodule

/* design/vpsm_dpath.sv */
// datapath of the vector pair similarity metrics block
// element stores, accumulators, correlation sweep, divider, multiplier, root; uses vpsm_pkg
module vpsm_dpath import vpsm_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vpsm_cmd_t          cmd,
  output vpsm_sts_t          sts,
  input  logic signed [15:0] first_value,
  input  logic signed [15:0] second_value,
  output logic [16:0]        visibility,
  output logic [16:0]        coherence,
  output logic signed [19:0] bell_excess,
  output logic [40:0]        ortho
);

  localparam int CW   = $clog2(MAX_DIM + 1);
  localparam int AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW   = 30 + CW;
  localparam int PW   = 2 * NW;
  localparam int DW   = PW + 32;
  localparam int TW   = 34 + CW;
  localparam int EW   = 35 + CW;
  localparam int MW   = (NW > 41) ? NW : 41;
  localparam int QW   = DIV_STEPS;

  logic signed [15:0] mem_a [MAX_DIM];
  logic signed [15:0] mem_b [MAX_DIM];

  logic [CW-1:0]        count_r;
  logic signed [NW:0]   dot_r;
  logic [NW-1:0]        n1_r, n2_r;
  logic [AW-1:0]        i_r, j1_r, j2_r;
  logic [AW-1:0]        last_idx;
  logic signed [15:0]   a0_r, a2_r, b0_r, b1_r;
  logic                 v1_r, v2_r;
  logic signed [32:0]   p0_r, p1_r;
  logic signed [TW-1:0] total_r;
  logic [DW-1:0]        rem_r, dsh_r;
  logic [QW-1:0]        q_r;
  logic [PW-1:0]        ma_r, acc_r, p_r;
  logic [NW-1:0]        mb_r;
  logic [16:0]          root_r, bit_r;
  logic signed [19:0]   exc_r;
  logic                 neg_r;
  logic [NW-1:0]        mag;
  logic signed [EW-1:0] num;
  logic [EW-1:0]        num_abs;
  logic signed [16:0]   sb_sum, sb_dif;
  logic [16:0]          trial;
  logic [33:0]          trial_sq;
  logic [MW-1:0]        mag_ext;
  logic                 room;

  assign room     = (count_r < CW'(MAX_DIM));
  assign last_idx = AW'(count_r - 1'b1);
  assign mag      = dot_r[NW] ? NW'(-dot_r) : NW'(dot_r);
  assign num      = EW'(total_r) - (EW'(count_r) <<< 31);
  assign num_abs  = num[EW-1] ? EW'(-num) : EW'(num);
  assign sb_sum   = 17'(b0_r) + 17'(b1_r);
  assign sb_dif   = 17'(b0_r) - 17'(b1_r);
  assign trial    = root_r | bit_r;
  assign trial_sq = 34'(trial) * 34'(trial);
  assign mag_ext  = MW'(mag);

  assign sts.sweep_last = (i_r == last_idx);
  assign sts.zero_norm  = (n1_r == '0) || (n2_r == '0);

  // loading: stores and running sums; store reads for the sweep
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem_a[count_r[AW-1:0]] <= first_value;
      mem_b[count_r[AW-1:0]] <= second_value;
    end
    if (cmd.sweep_rd) begin
      a0_r <= mem_a[i_r];
      a2_r <= mem_a[j2_r];
      b0_r <= mem_b[i_r];
      b1_r <= mem_b[j1_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dot_r   <= '0;
      n1_r    <= '0;
      n2_r    <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      v1_r <= cmd.sweep_rd;
      v2_r <= v1_r;
      if (cmd.clear) begin
        count_r <= '0;
        dot_r   <= '0;
        n1_r    <= '0;
        n2_r    <= '0;
      end else if (cmd.load && room) begin
        count_r <= count_r + 1'b1;
        dot_r   <= dot_r + (NW+1)'(first_value * second_value);
        n1_r    <= n1_r + NW'($unsigned(32'(first_value * first_value)));
        n2_r    <= n2_r + NW'($unsigned(32'(second_value * second_value)));
      end
    end
  end

  // correlation sweep: index walkers, products, sum
  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      i_r     <= '0;
      j1_r    <= (count_r == CW'(1)) ? '0 : AW'(1);
      j2_r    <= (count_r == CW'(1) || count_r == CW'(2)) ? '0 : AW'(2);
      total_r <= '0;
    end else begin
      if (cmd.sweep_rd) begin
        i_r  <= i_r + 1'b1;
        j1_r <= (j1_r == last_idx) ? '0 : j1_r + 1'b1;
        j2_r <= (j2_r == last_idx) ? '0 : j2_r + 1'b1;
      end
      if (v2_r) begin
        total_r <= total_r + TW'(p0_r) + TW'(p1_r);
      end
    end
    if (v1_r) begin
      p0_r <= 33'(a0_r) * 33'(sb_sum);
      p1_r <= 33'(a2_r) * 33'(sb_dif);
    end
  end

  // restoring divider, shift-add multiplier, digit-by-digit root
  always_ff @(posedge clk) begin
    if (cmd.div_ex_init) begin
      rem_r <= DW'(num_abs);
      dsh_r <= DW'(count_r) << 46;
      q_r   <= '0;
      neg_r <= num[EW-1];
    end else if (cmd.div_q_init) begin
      rem_r <= DW'(acc_r) << 32;
      dsh_r <= DW'(p_r) << 32;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r <= {q_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.ex_latch) begin
      exc_r <= neg_r ? -q_r[19:0] : q_r[19:0];
    end
    if (cmd.p_latch) begin
      p_r <= acc_r;
    end
    if (cmd.mul_p_init) begin
      ma_r  <= PW'(n1_r);
      mb_r  <= n2_r;
      acc_r <= '0;
    end else if (cmd.mul_d_init) begin
      ma_r  <= PW'(mag);
      mb_r  <= mag;
      acc_r <= '0;
    end else if (cmd.mul_step) begin
      if (mb_r[0]) begin
        acc_r <= acc_r + ma_r;
      end
      ma_r <= ma_r << 1;
      mb_r <= mb_r >> 1;
    end
    if (cmd.sqrt_init) begin
      root_r <= '0;
      bit_r  <= 17'h10000;
    end else if (cmd.sqrt_step) begin
      if (trial_sq <= 34'(q_r)) begin
        root_r <= trial;
      end
      bit_r <= bit_r >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      visibility  <= sts.zero_norm ? '0 : q_r[32:16];
      coherence   <= sts.zero_norm ? '0 : root_r;
      bell_excess <= exc_r;
      ortho       <= (mag_ext > MW'(41'h1FFFFFFFFFF)) ? 41'h1FFFFFFFFFF : mag_ext[40:0];
    end
  end

endmodule
